// File: hw/rtl/fnvp_pkg.sv
package fnvp_pkg;

    // Widths of the stream fields.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 31;
    localparam int ROLE_W = 2;
    localparam int PH_W   = 3;
    localparam int HBC_W  = 2;

    // Output tdata: out_byte, name_length, value_length, padded to whole bytes.
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - BYTE_W - 2 * LEN_W;

    // Decoder phases.
    localparam logic [PH_W-1:0] PH_NAME_LEN       = 3'd0;
    localparam logic [PH_W-1:0] PH_NAME_LEN_MORE  = 3'd1;
    localparam logic [PH_W-1:0] PH_VALUE_LEN      = 3'd2;
    localparam logic [PH_W-1:0] PH_VALUE_LEN_MORE = 3'd3;
    localparam logic [PH_W-1:0] PH_NAME           = 3'd4;
    localparam logic [PH_W-1:0] PH_VALUE          = 3'd5;
    localparam logic [PH_W-1:0] PH_ERROR          = 3'd6;

    // Byte roles reported in tuser.
    localparam logic [ROLE_W-1:0] ROLE_HEADER = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_NAME   = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_VALUE  = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_ERROR  = 2'd3;

    // Multi-byte lengths carry three more bytes after the first.
    localparam logic [HBC_W-1:0] HBC_LAST = 2'd2;

    // Configuration register map.
    localparam int          APB_ADDR_W          = 2;
    localparam logic [1:0]  ADDR_MAX_LENGTH     = 2'd0;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 31'd65535;

    // One decoded result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [ROLE_W-1:0] role;
        logic              pair_end;
        logic [LEN_W-1:0]  name_length;
        logic [LEN_W-1:0]  value_length;
    } fnvp_result_t;

endpackage

// File: hw/rtl/fnvp_skid.sv
module fnvp_skid (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fnvp_pkg::fnvp_result_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fnvp_pkg::fnvp_result_t out_data
);
    import fnvp_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    fnvp_result_t main_data_reg;
    fnvp_result_t skid_data_reg;
    logic         main_free;

    // The input side only stalls once the skid entry is occupied.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign main_free = !main_valid_reg || out_ready;

    // Control flags for the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_data_reg <= skid_data_reg;
            end
            else
            begin
                main_data_reg <= in_data;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// File: hw/rtl/fastcgi_name_value_parser_unit.sv
// FastCGI name-value pair decoder, one stream byte per transaction.
// Each result is registered in the output stage (main entry, or skid entry then main entry) before the master side.
// Throughput: one byte per cycle while m_tready keeps up; the two-entry output stage absorbs one byte during a stall.
// Reset: rst_n clears the phase, counters, length registers and output stage valid flags at once;
// max_length returns to 65535.
module fastcgi_name_value_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fnvp_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] data_byte
    input  logic                                s_tuser,  // [0] restart
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fnvp_pkg::M_TDATA_W-1:0]      m_tdata,  // [7:0] out_byte, [38:8] name_length,
                                                          // [69:39] value_length, [71:70] zero
    output logic [fnvp_pkg::ROLE_W-1:0]         m_tuser,  // [1:0] role
    output logic                                m_tlast,  // pair_end
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fnvp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import fnvp_pkg::*;

    logic [LEN_W-1:0]  max_length_reg;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [HBC_W-1:0]  hbc_reg, hbc_next;
    logic [LEN_W-1:0]  name_len_reg, name_len_next;
    logic [LEN_W-1:0]  value_len_reg, value_len_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;

    logic [PH_W-1:0]   cur_phase;
    logic [HBC_W-1:0]  cur_hbc;
    logic [BYTE_W-1:0] b;
    logic              hdr_done;
    logic [ROLE_W-1:0] role;
    logic              pair_end;
    logic              s_fire;
    logic              cfg_write;
    fnvp_result_t      result;
    fnvp_result_t      out_result;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_MAX_LENGTH) ? {1'b0, max_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_write && (paddr == ADDR_MAX_LENGTH))
        begin
            max_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign s_fire = s_tvalid && s_tready;
    assign b      = s_tdata;

    // Next-state decode for one byte.
    always_comb
    begin
        cur_phase      = s_tuser ? PH_NAME_LEN : phase_reg;
        cur_hbc        = s_tuser ? '0 : hbc_reg;
        phase_next     = cur_phase;
        hbc_next       = cur_hbc;
        name_len_next  = name_len_reg;
        value_len_next = value_len_reg;
        remaining_next = remaining_reg;
        role           = ROLE_HEADER;
        pair_end       = 1'b0;
        hdr_done       = 1'b0;

        case (cur_phase)
            PH_NAME_LEN:
            begin
                value_len_next = '0;
                remaining_next = '0;
                hbc_next       = '0;
                if (!b[BYTE_W-1])
                begin
                    name_len_next = {{(LEN_W-BYTE_W){1'b0}}, b};
                    phase_next    = PH_VALUE_LEN;
                end
                else
                begin
                    name_len_next = {{(LEN_W-BYTE_W+1){1'b0}}, b[BYTE_W-2:0]};
                    phase_next    = PH_NAME_LEN_MORE;
                end
            end
            PH_NAME_LEN_MORE:
            begin
                name_len_next = {name_len_reg[LEN_W-BYTE_W-1:0], b};
                hbc_next      = cur_hbc + 2'd1;
                if (cur_hbc == HBC_LAST)
                begin
                    hbc_next   = '0;
                    phase_next = PH_VALUE_LEN;
                end
            end
            PH_VALUE_LEN:
            begin
                hbc_next = '0;
                if (!b[BYTE_W-1])
                begin
                    value_len_next = {{(LEN_W-BYTE_W){1'b0}}, b};
                    hdr_done       = 1'b1;
                end
                else
                begin
                    value_len_next = {{(LEN_W-BYTE_W+1){1'b0}}, b[BYTE_W-2:0]};
                    phase_next     = PH_VALUE_LEN_MORE;
                end
            end
            PH_VALUE_LEN_MORE:
            begin
                value_len_next = {value_len_reg[LEN_W-BYTE_W-1:0], b};
                hbc_next       = cur_hbc + 2'd1;
                if (cur_hbc == HBC_LAST)
                begin
                    hbc_next = '0;
                    hdr_done = 1'b1;
                end
            end
            PH_NAME:
            begin
                role           = ROLE_NAME;
                remaining_next = remaining_reg - 31'd1;
                if (remaining_next == '0)
                begin
                    if (value_len_reg != '0)
                    begin
                        remaining_next = value_len_reg;
                        phase_next     = PH_VALUE;
                    end
                    else
                    begin
                        pair_end   = 1'b1;
                        phase_next = PH_NAME_LEN;
                    end
                end
            end
            PH_VALUE:
            begin
                role           = ROLE_VALUE;
                remaining_next = remaining_reg - 31'd1;
                if (remaining_next == '0)
                begin
                    pair_end   = 1'b1;
                    phase_next = PH_NAME_LEN;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
                role       = ROLE_ERROR;
            end
        endcase

        // Header complete: check limits and pick the first body section.
        if (hdr_done)
        begin
            if ((name_len_reg > max_length_reg) || (value_len_next > max_length_reg))
            begin
                phase_next = PH_ERROR;
                role       = ROLE_ERROR;
            end
            else if (name_len_reg != '0)
            begin
                remaining_next = name_len_reg;
                phase_next     = PH_NAME;
            end
            else if (value_len_next != '0)
            begin
                remaining_next = value_len_next;
                phase_next     = PH_VALUE;
            end
            else
            begin
                pair_end   = 1'b1;
                phase_next = PH_NAME_LEN;
            end
        end
    end

    // Decoder state advances on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NAME_LEN;
            hbc_reg       <= '0;
            name_len_reg  <= '0;
            value_len_reg <= '0;
            remaining_reg <= '0;
        end
        else if (s_fire)
        begin
            phase_reg     <= phase_next;
            hbc_reg       <= hbc_next;
            name_len_reg  <= name_len_next;
            value_len_reg <= value_len_next;
            remaining_reg <= remaining_next;
        end
    end

    // Result item for this byte.
    always_comb
    begin
        result.out_byte     = b;
        result.role         = role;
        result.pair_end     = pair_end;
        result.name_length  = name_len_next;
        result.value_length = value_len_next;
    end

    fnvp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Output packing.
    assign m_tdata = {{M_PAD_W{1'b0}}, out_result.value_length,
                      out_result.name_length, out_result.out_byte};
    assign m_tuser = out_result.role;
    assign m_tlast = out_result.pair_end;

endmodule
